// ===== sv/join_pair_selection_flags_macros.svh =====
// ----------------------------------------------------------------------------
// join_pair_selection_flags_macros
// Assertion helpers shared by the join pair selection block.
// ----------------------------------------------------------------------------
`ifndef JOIN_PAIR_SELECTION_FLAGS_MACROS_SVH
`define JOIN_PAIR_SELECTION_FLAGS_MACROS_SVH

// same-cycle implication, quiet during reset
`define JPSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define JPSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// jpsf_pkg
// Shared types, codes and mode decode for the join pair selection block.
// ----------------------------------------------------------------------------
package jpsf_pkg;

  // default table sizes
  localparam int PROBE_ROWS_DEFAULT = 65536;
  localparam int BUILD_ROWS_DEFAULT = 65536;

  // flag memories hold one flag bit per row, WORD_BITS flags to a word
  localparam int WORD_BITS = 32;
  localparam int OFF_W     = 5;

  // item kinds
  typedef enum logic [1:0] {
    KIND_PAIR        = 2'd0,
    KIND_CLEAR       = 2'd1,
    KIND_QUERY_PROBE = 2'd2,
    KIND_QUERY_BUILD = 2'd3
  } item_kind_t;

  // register indexes
  localparam logic [1:0] REG_JOIN_KIND       = 2'd0;
  localparam logic [1:0] REG_JOIN_STRICTNESS = 2'd1;
  localparam logic [1:0] REG_BUILD_FLAGS     = 2'd2;
  localparam logic [1:0] REG_UNMATCHED_BUILD = 2'd3;

  // join kinds
  localparam logic [2:0] JK_INNER = 3'd0;
  localparam logic [2:0] JK_LEFT  = 3'd1;
  localparam logic [2:0] JK_RIGHT = 3'd2;
  localparam logic [2:0] JK_FULL  = 3'd3;
  localparam logic [2:0] JK_CROSS = 3'd4;
  localparam logic [2:0] JK_COMMA = 3'd5;

  // join strictness
  localparam logic [2:0] ST_ALL       = 3'd0;
  localparam logic [2:0] ST_ANY       = 3'd1;
  localparam logic [2:0] ST_SEMI      = 3'd2;
  localparam logic [2:0] ST_RIGHT_ANY = 3'd3;
  localparam logic [2:0] ST_ANTI      = 3'd4;

  // selection rule
  typedef enum logic [2:0] {
    SEL_ALL,
    SEL_FIRST_PROBE,
    SEL_FIRST_BUILD,
    SEL_BOTH,
    SEL_NONE,
    SEL_BAD
  } sel_t;

  typedef struct packed {
    sel_t sel;
    logic claim;
    logic err;
    logic early;
    logic keep_up;
    logic track;
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic read;
    logic sweep;
    logic sweep_all;
    logic decide;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic clear_item;
  } dp_status_t;

  // derive the selection rule and its side flags from the mode registers
  function automatic mode_t decode_mode(logic [2:0] jk, logic [2:0] js,
                                        logic bfk, logic ubw);
    mode_t m;
    sel_t  s;
    if (jk > JK_COMMA) begin
      s = SEL_BAD;
    end else if (jk == JK_CROSS || jk == JK_COMMA) begin
      s = SEL_ALL;
    end else begin
      unique case (js)
        ST_ALL:       s = SEL_ALL;
        ST_ANY:       s = (jk == JK_INNER) ? SEL_BOTH :
                          (jk == JK_RIGHT) ? SEL_FIRST_BUILD : SEL_FIRST_PROBE;
        ST_SEMI:      s = (jk == JK_RIGHT) ? SEL_FIRST_BUILD : SEL_FIRST_PROBE;
        ST_RIGHT_ANY: s = SEL_FIRST_PROBE;
        ST_ANTI:      s = SEL_NONE;
        default:      s = SEL_BAD;
      endcase
    end
    m.sel   = s;
    m.claim = (s == SEL_FIRST_BUILD) || (s == SEL_BOTH);
    m.err   = (s == SEL_BAD) || (m.claim && !bfk);
    m.early = (s != SEL_ALL) && (s != SEL_FIRST_BUILD) && !ubw;
    if (js == ST_SEMI) begin
      m.keep_up = 1'b0;
    end else if (js == ST_ANTI) begin
      m.keep_up = (jk == JK_LEFT);
    end else begin
      m.keep_up = (jk == JK_LEFT) || (jk == JK_FULL);
    end
    m.track = m.keep_up || m.early || (s == SEL_FIRST_PROBE) || (s == SEL_BOTH);
    return m;
  endfunction

endpackage

// ===== sv/jpsf_dp.sv =====
// ----------------------------------------------------------------------------
// jpsf_dp
// Datapath: mode registers, item latch, probe and build flag memories,
// clearing sweep counter, pair decision and result registers.
// ----------------------------------------------------------------------------
module jpsf_dp
  import jpsf_pkg::*;
#(
  parameter int PROBE_ROWS = PROBE_ROWS_DEFAULT,
  parameter int BUILD_ROWS = BUILD_ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic [1:0]  kind,
  input  logic [15:0] probe_index,
  input  logic [15:0] build_index,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        pair_kept,
  output logic [15:0] out_probe_index,
  output logic [15:0] out_build_index,
  output logic        probe_settled,
  output logic        needs_padding,
  output logic        mode_error
);

  localparam int P_DEPTH = (PROBE_ROWS + WORD_BITS - 1) / WORD_BITS;
  localparam int B_DEPTH = (BUILD_ROWS + WORD_BITS - 1) / WORD_BITS;
  localparam int M_DEPTH = (P_DEPTH > B_DEPTH) ? P_DEPTH : B_DEPTH;
  localparam int P_AW    = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CNT_W   = (M_DEPTH > 1) ? $clog2(M_DEPTH) : 1;

  // mode registers
  logic [2:0] join_kind;
  logic [2:0] join_strictness;
  logic       build_flags_kept;
  logic       unmatched_build_wanted;

  // latched item
  item_kind_t  kind_q;
  logic [15:0] p_q;
  logic [15:0] b_q;

  // flag memories and registered read words
  logic [WORD_BITS-1:0] probe_mem [P_DEPTH];
  logic [WORD_BITS-1:0] build_mem [B_DEPTH];
  logic [WORD_BITS-1:0] probe_word;
  logic [WORD_BITS-1:0] build_word;

  // sweep counter
  logic [CNT_W-1:0] sweep_cnt;
  logic [CNT_W-1:0] sweep_cnt_next;

  // decided result, waiting for the output register
  logic        res_kept;
  logic [15:0] res_probe;
  logic [15:0] res_build;
  logic        res_settled;
  logic        res_pad;
  logic        res_err;

  mode_t       mode;
  logic [31:0] p_row32;
  logic [31:0] b_row32;
  logic [P_AW-1:0] p_addr;
  logic [B_AW-1:0] b_addr;
  logic        p_ok;
  logic        b_ok;
  logic        pbit;
  logic        bbit;
  logic        valid_pair;
  logic        selected;
  logic        set_p;
  logic        set_b;
  logic        d_kept;
  logic        d_settled;
  logic        d_pad;
  logic [15:0] d_probe;
  logic [15:0] d_build;
  logic        p_we;
  logic        b_we;
  logic [P_AW-1:0] p_waddr;
  logic [B_AW-1:0] b_waddr;
  logic [WORD_BITS-1:0] p_wdata;
  logic [WORD_BITS-1:0] b_wdata;
  logic        sweep_p_in;
  logic        sweep_b_in;

  // mode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      join_kind              <= JK_INNER;
      join_strictness        <= ST_ALL;
      build_flags_kept       <= 1'b0;
      unmatched_build_wanted <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_JOIN_KIND:       join_kind              <= cfg_data;
        REG_JOIN_STRICTNESS: join_strictness        <= cfg_data;
        REG_BUILD_FLAGS:     build_flags_kept       <= cfg_data[0];
        REG_UNMATCHED_BUILD: unmatched_build_wanted <= cfg_data[0];
      endcase
    end
  end

  assign mode = decode_mode(join_kind, join_strictness, build_flags_kept,
                            unmatched_build_wanted);

  // item latch
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_q <= KIND_PAIR;
    end else if (cmd.take) begin
      kind_q <= item_kind_t'(kind);
    end
    if (cmd.take) begin
      p_q    <= probe_index;
      b_q    <= build_index;
    end
  end

  // row addresses and range checks
  assign p_row32 = 32'(p_q) >> OFF_W;
  assign b_row32 = 32'(b_q) >> OFF_W;
  assign p_addr  = p_row32[P_AW-1:0];
  assign b_addr  = b_row32[B_AW-1:0];
  assign p_ok    = 32'(p_q) < 32'(PROBE_ROWS);
  assign b_ok    = 32'(b_q) < 32'(BUILD_ROWS);
  assign pbit    = probe_word[p_q[OFF_W-1:0]];
  assign bbit    = build_word[b_q[OFF_W-1:0]];

  // pair decision and query answers
  always_comb begin
    valid_pair = (kind_q == KIND_PAIR) && !mode.err && p_ok && b_ok;
    unique case (mode.sel)
      SEL_ALL:         selected = 1'b1;
      SEL_FIRST_PROBE: selected = !pbit;
      SEL_FIRST_BUILD: selected = !bbit;
      SEL_BOTH:        selected = !pbit && !bbit;
      default:         selected = 1'b0;
    endcase
    set_p     = valid_pair && mode.track && (selected || mode.sel != SEL_BOTH);
    set_b     = valid_pair && ((mode.claim && selected) ||
                               (build_flags_kept && !mode.claim));
    d_kept    = valid_pair && selected;
    d_settled = valid_pair && mode.early && (pbit || set_p);
    d_pad     = 1'b0;
    d_probe   = 16'd0;
    d_build   = 16'd0;
    unique case (kind_q)
      KIND_PAIR: begin
        d_probe = p_q;
        d_build = b_q;
      end
      KIND_CLEAR: begin
        d_pad = 1'b0;
      end
      KIND_QUERY_PROBE: begin
        d_probe = p_q;
        d_pad   = !mode.err && p_ok && mode.keep_up && !pbit;
      end
      KIND_QUERY_BUILD: begin
        d_build = b_q;
        d_pad   = !mode.err && b_ok && build_flags_kept && unmatched_build_wanted
                  && !bbit;
      end
    endcase
  end

  // sweep counter walks rows, wraps at the end of the pass
  assign sweep_p_in = 32'(sweep_cnt) < 32'(P_DEPTH);
  assign sweep_b_in = 32'(sweep_cnt) < 32'(B_DEPTH);
  assign status.sweep_last = cmd.sweep_all ? (32'(sweep_cnt) == 32'(M_DEPTH - 1))
                                           : (32'(sweep_cnt) == 32'(P_DEPTH - 1));
  assign status.clear_item = (kind_q == KIND_CLEAR);
  assign sweep_cnt_next = status.sweep_last ? '0 : sweep_cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt_next;
    end
  end

  // memory write port select: sweep clears, decide sets one flag
  always_comb begin
    if (cmd.sweep) begin
      p_we    = sweep_p_in;
      p_waddr = sweep_cnt[P_AW-1:0];
      p_wdata = '0;
      b_we    = cmd.sweep_all && sweep_b_in;
      b_waddr = sweep_cnt[B_AW-1:0];
      b_wdata = '0;
    end else begin
      p_we    = cmd.decide && set_p;
      p_waddr = p_addr;
      p_wdata = probe_word | (WORD_BITS'(1) << p_q[OFF_W-1:0]);
      b_we    = cmd.decide && set_b;
      b_waddr = b_addr;
      b_wdata = build_word | (WORD_BITS'(1) << b_q[OFF_W-1:0]);
    end
  end

  // probe flag memory
  always_ff @(posedge clk) begin
    if (p_we) begin
      probe_mem[p_waddr] <= p_wdata;
    end
    if (cmd.read) begin
      probe_word <= probe_mem[p_addr];
    end
  end

  // build flag memory
  always_ff @(posedge clk) begin
    if (b_we) begin
      build_mem[b_waddr] <= b_wdata;
    end
    if (cmd.read) begin
      build_word <= build_mem[b_addr];
    end
  end

  // decided result
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_kept    <= d_kept;
      res_probe   <= d_probe;
      res_build   <= d_build;
      res_settled <= d_settled;
      res_pad     <= d_pad;
      res_err     <= mode.err;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pair_kept       <= res_kept;
      out_probe_index <= res_probe;
      out_build_index <= res_build;
      probe_settled   <= res_settled;
      needs_padding   <= res_pad;
      mode_error      <= res_err;
    end
  end

endmodule

// ===== sv/jpsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// jpsf_ctrl
// Controller: reset clearing pass, item sequencing and output word valid.
// ----------------------------------------------------------------------------
`include "join_pair_selection_flags_macros.svh"

module jpsf_ctrl
  import jpsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  output logic       result_valid,
  input  logic       result_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;
  logic   result_valid_next;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // commands follow the state
  always_comb begin
    cmd           = '0;
    cmd.take      = accept;
    cmd.read      = (state == S_READ);
    cmd.sweep     = (state == S_INIT) || (state == S_CLEAR);
    cmd.sweep_all = (state == S_INIT);
    cmd.decide    = (state == S_DECIDE);
    cmd.emit      = (state == S_EMIT) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (status.sweep_last) state_next = S_IDLE;
      S_IDLE:   if (accept) state_next = S_READ;
      S_READ:   state_next = status.clear_item ? S_CLEAR : S_DECIDE;
      S_CLEAR:  if (status.sweep_last) state_next = S_DECIDE;
      S_DECIDE: state_next = S_EMIT;
      S_EMIT:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  assign result_valid_next = cmd.emit || (result_valid && result_stall);

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // checks
  `JPSF_ASSERT_NEXT(a_accept_busy, accept, state == S_READ, "accepted item not started")
  `JPSF_ASSERT_NOW(a_emit_free, cmd.emit, !(result_valid && result_stall), "emit over held word")
  `JPSF_ASSERT_NEXT(a_emit_shows, cmd.emit, result_valid && state == S_IDLE, "emitted word lost")
  `JPSF_ASSERT_NOW(a_init_no_decide, state == S_INIT, !cmd.decide && !result_valid, "work during init")

endmodule

// ===== sv/join_pair_selection_flags.sv =====
// ----------------------------------------------------------------------------
// join_pair_selection_flags
// Pair selection and match flag bookkeeping for a keyless nested-loop join.
// ----------------------------------------------------------------------------
// Usage:
//   Mode registers are written through cfg_write / cfg_index / cfg_data while
//   the block is idle. Items enter on item_valid / item_stall (kind,
//   probe_index, build_index); each item gives exactly one result word on
//   result_valid / result_stall.
//   For pair and query items the result word passes through the flag memory
//   read, the decide and write back, and the output load after the item is
//   accepted. A new item is not taken until the word of the last one has
//   been loaded into the output register.
//   A clear item walks the probe flag memory one 32-flag row per cycle,
//   PROBE_ROWS/32 rows (2048 at defaults), and then answers.
//   After reset both flag memories are cleared in one pass over
//   max(PROBE_ROWS, BUILD_ROWS)/32 rows (2048 at defaults) with item_stall
//   held high; mode registers may still be written.
//   When result_stall is high the result word is held in the output register;
//   one more item may be accepted and finished behind it, after which
//   item_stall stays high until the word is taken.
// ----------------------------------------------------------------------------
module join_pair_selection_flags
  import jpsf_pkg::*;
#(
  parameter int PROBE_ROWS = PROBE_ROWS_DEFAULT,
  parameter int BUILD_ROWS = BUILD_ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] probe_index,
  input  logic [15:0] build_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        pair_kept,
  output logic [15:0] out_probe_index,
  output logic [15:0] out_build_index,
  output logic        probe_settled,
  output logic        needs_padding,
  output logic        mode_error
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  jpsf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // flags, decision and result word
  jpsf_dp #(
    .PROBE_ROWS (PROBE_ROWS),
    .BUILD_ROWS (BUILD_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .probe_index     (probe_index),
    .build_index     (build_index),
    .cmd             (cmd),
    .status          (status),
    .pair_kept       (pair_kept),
    .out_probe_index (out_probe_index),
    .out_build_index (out_build_index),
    .probe_settled   (probe_settled),
    .needs_padding   (needs_padding),
    .mode_error      (mode_error)
  );

endmodule

// ===== tb/sv/tb_join_pair_selection_flags.sv =====
// ----------------------------------------------------------------------------
// tb_join_pair_selection_flags
// Self-checking bench for the join pair selection block. A scoreboard class
// keeps its own probe and build flag bitmaps and mode registers, works out
// the result word of every accepted item and checks the block's words in
// order. Stimulus is a short directed part, then random phases over many
// mode settings with random sender gaps, receiver stalls and long hold-offs.
// ----------------------------------------------------------------------------
module tb_join_pair_selection_flags;
  import jpsf_pkg::*;

  // mode register values with no name in the package
  localparam logic [2:0] JK_UNUSED_LO = 3'd6;
  localparam logic [2:0] JK_UNUSED_HI = 3'd7;
  localparam logic [2:0] ST_UNUSED_LO = 3'd5;
  localparam logic [2:0] ST_UNUSED_MID = 3'd6;
  localparam logic [2:0] ST_UNUSED_HI = 3'd7;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASE_COUNT    = 16;
  localparam int PHASE_ITEMS    = 85;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic        kept;
    logic [15:0] p_echo;
    logic [15:0] b_echo;
    logic        settled;
    logic        pad;
    logic        err;
  } flag_result_t;

  typedef struct packed {
    logic [2:0] jk;
    logic [2:0] js;
    logic       bfk;
    logic       ubw;
  } mode_setting_t;

  // mode settings walked by the random phases
  localparam mode_setting_t PLAN [PHASE_COUNT] = '{
    '{JK_INNER,     ST_ALL,        1'b1, 1'b0},
    '{JK_LEFT,      ST_ANY,        1'b1, 1'b0},
    '{JK_RIGHT,     ST_ANY,        1'b1, 1'b1},
    '{JK_FULL,      ST_ALL,        1'b1, 1'b1},
    '{JK_INNER,     ST_ANY,        1'b1, 1'b0},
    '{JK_LEFT,      ST_SEMI,       1'b0, 1'b0},
    '{JK_RIGHT,     ST_SEMI,       1'b1, 1'b1},
    '{JK_FULL,      ST_RIGHT_ANY,  1'b1, 1'b0},
    '{JK_LEFT,      ST_ANTI,       1'b1, 1'b1},
    '{JK_CROSS,     ST_ANY,        1'b0, 1'b1},
    '{JK_COMMA,     ST_ANTI,       1'b1, 1'b0},
    '{JK_UNUSED_HI, ST_UNUSED_HI,  1'b1, 1'b1},
    '{JK_INNER,     ST_UNUSED_LO,  1'b0, 1'b0},
    '{JK_RIGHT,     ST_ANY,        1'b0, 1'b0},
    '{JK_FULL,      ST_ANTI,       1'b0, 1'b1},
    '{JK_INNER,     ST_SEMI,       1'b1, 1'b1}
  };

  // scoreboard: flag bitmaps, mode registers and the words still to come
  class pair_flag_board;
    bit           probe_hit [PROBE_ROWS_DEFAULT];
    bit           build_hit [BUILD_ROWS_DEFAULT];
    bit [2:0]     jkind = '0;
    bit [2:0]     jstrict = '0;
    bit           flags_kept = 1'b0;
    bit           want_build_pad = 1'b0;
    flag_result_t expected_words [$];
    int           n_errors = 0;
    int           n_checked = 0;
    int           n_kept = 0;
    int           n_clears = 0;

    function void write_reg(logic [1:0] idx, logic [2:0] data);
      case (idx)
        REG_JOIN_KIND:       jkind = data;
        REG_JOIN_STRICTNESS: jstrict = data;
        REG_BUILD_FLAGS:     flags_kept = data[0];
        REG_UNMATCHED_BUILD: want_build_pad = data[0];
        default: ;
      endcase
    endfunction

    // selection rule from join kind and strictness
    function sel_t rule();
      if (jkind > JK_COMMA) return SEL_BAD;
      if (jkind == JK_CROSS || jkind == JK_COMMA) return SEL_ALL;
      case (jstrict)
        ST_ALL:       return SEL_ALL;
        ST_ANY: begin
          if (jkind == JK_INNER) return SEL_BOTH;
          return (jkind == JK_RIGHT) ? SEL_FIRST_BUILD : SEL_FIRST_PROBE;
        end
        ST_SEMI:      return (jkind == JK_RIGHT) ? SEL_FIRST_BUILD : SEL_FIRST_PROBE;
        ST_RIGHT_ANY: return SEL_FIRST_PROBE;
        ST_ANTI:      return SEL_NONE;
        default:      return SEL_BAD;
      endcase
    endfunction

    // unmatched probe rows are emitted padded
    function bit pads_probe();
      if (jstrict == ST_SEMI) return 1'b0;
      if (jstrict == ST_ANTI) return jkind == JK_LEFT;
      return jkind == JK_LEFT || jkind == JK_FULL;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // work out the word of one accepted item and update the bitmaps
    function void note_item(item_kind_t k, logic [15:0] p, logic [15:0] b);
      flag_result_t r;
      sel_t         s;
      bit           claim, err, early, keep_up, track, picked;
      s       = rule();
      claim   = (s == SEL_FIRST_BUILD) || (s == SEL_BOTH);
      err     = (s == SEL_BAD) || (claim && !flags_kept);
      early   = (s != SEL_ALL) && (s != SEL_FIRST_BUILD) && !want_build_pad;
      keep_up = pads_probe();
      track   = keep_up || early || (s == SEL_FIRST_PROBE) || (s == SEL_BOTH);
      picked  = 1'b0;
      r       = '0;
      case (k)
        KIND_PAIR: begin
          r.p_echo = p;
          r.b_echo = b;
          if (!err) begin
            case (s)
              SEL_ALL:         picked = 1'b1;
              SEL_FIRST_PROBE: picked = !probe_hit[p];
              SEL_FIRST_BUILD: begin
                picked = !build_hit[b];
                if (picked) build_hit[b] = 1'b1;
              end
              SEL_BOTH: begin
                picked = !probe_hit[p] && !build_hit[b];
                if (picked) build_hit[b] = 1'b1;
              end
              default: ;
            endcase
            if (track && (picked || s != SEL_BOTH)) probe_hit[p] = 1'b1;
            if (flags_kept && !claim) build_hit[b] = 1'b1;
            r.kept    = picked;
            r.settled = early && probe_hit[p];
            if (picked) n_kept++;
          end
        end
        KIND_CLEAR: begin
          foreach (probe_hit[i]) probe_hit[i] = 1'b0;
          n_clears++;
        end
        KIND_QUERY_PROBE: begin
          r.p_echo = p;
          r.pad = !err && keep_up && !probe_hit[p];
        end
        default: begin
          r.b_echo = b;
          r.pad = !err && flags_kept && want_build_pad && !build_hit[b];
        end
      endcase
      r.err = err;
      expected_words = {expected_words, r};
    endfunction

    function void match_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        n_errors++;
      end
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(logic kept, logic [15:0] op, logic [15:0] ob,
                             logic settled, logic pad, logic err);
      flag_result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with no item waiting");
        n_errors++;
        return;
      end
      want = expected_words[0];
      expected_words.delete(0);
      n_checked++;
      match_field("pair_kept", want.kept, kept);
      match_field("out_probe_index", want.p_echo, op);
      match_field("out_build_index", want.b_echo, ob);
      match_field("probe_settled", want.settled, settled);
      match_field("needs_padding", want.pad, pad);
      match_field("mode_error", want.err, err);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [2:0]  cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  kind = '0;
  logic [15:0] probe_index = '0;
  logic [15:0] build_index = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        pair_kept;
  logic [15:0] out_probe_index;
  logic [15:0] out_build_index;
  logic        probe_settled;
  logic        needs_padding;
  logic        mode_error;

  pair_flag_board board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int n_sent = 0;
  int n_settings = 0;

  join_pair_selection_flags DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .kind            (kind),
    .probe_index     (probe_index),
    .build_index     (build_index),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .pair_kept       (pair_kept),
    .out_probe_index (out_probe_index),
    .out_build_index (out_build_index),
    .probe_settled   (probe_settled),
    .needs_padding   (needs_padding),
    .mode_error      (mode_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted words, then pick the next stall
  always @(posedge clk) begin
    int hold_left;
    if (!rst && result_valid && !result_stall)
      board.check_word(pair_kept, out_probe_index, out_build_index,
                       probe_settled, needs_padding, mode_error);
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // write all four mode registers; spare data bits of one-bit registers are random
  task automatic apply_mode(mode_setting_t m);
    logic [2:0] spare;
    spare = 3'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_JOIN_KIND;
    cfg_data  <= m.jk;
    @(posedge clk);
    board.write_reg(REG_JOIN_KIND, m.jk);
    cfg_index <= REG_JOIN_STRICTNESS;
    cfg_data  <= m.js;
    @(posedge clk);
    board.write_reg(REG_JOIN_STRICTNESS, m.js);
    cfg_index <= REG_BUILD_FLAGS;
    cfg_data  <= {spare[2:1], m.bfk};
    @(posedge clk);
    board.write_reg(REG_BUILD_FLAGS, {spare[2:1], m.bfk});
    cfg_index <= REG_UNMATCHED_BUILD;
    cfg_data  <= {spare[1:0], m.ubw};
    @(posedge clk);
    board.write_reg(REG_UNMATCHED_BUILD, {spare[1:0], m.ubw});
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(item_kind_t k, logic [15:0] p, logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    probe_index <= p;
    build_index <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(k, p, b);
    n_sent++;
  endtask

  // called in the step of the last acceptance: drop valid, wait for all words
  task automatic finish_burst();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // random phase: mostly pairs and queries over a small window of rows so
  // flags get hit again, a tenth over the full index range, rare clears
  task automatic run_phase(int n, int hold_at);
    logic [15:0] pbase, bbase, p, b;
    item_kind_t  k;
    int          roll;
    pbase = 16'($urandom);
    bbase = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_request = HOLD_OFF_CYCLES;
      roll = $urandom_range(999);
      if (roll < 12) k = KIND_CLEAR;
      else if (roll < 600) k = KIND_PAIR;
      else if (roll < 800) k = KIND_QUERY_PROBE;
      else k = KIND_QUERY_BUILD;
      if ($urandom_range(9) == 0) begin
        p = 16'($urandom);
        b = 16'($urandom);
      end else begin
        p = pbase + 16'($urandom_range(7));
        b = bbase + 16'($urandom_range(15));
      end
      send_word(k, p, b);
      // new chunk after a clear
      if (k == KIND_CLEAR) pbase = 16'($urandom);
    end
    finish_burst();
  endtask

  initial begin
    board = new;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: first per probe row with padding of unmatched probe rows
    apply_mode('{JK_LEFT, ST_ANY, 1'b1, 1'b0});
    send_word(KIND_QUERY_PROBE, 16'h0000, 16'h0000);
    send_word(KIND_PAIR,        16'h0000, 16'h0000);
    send_word(KIND_PAIR,        16'h0000, 16'h0001);
    send_word(KIND_QUERY_PROBE, 16'h0000, 16'hffff);
    send_word(KIND_QUERY_BUILD, 16'hffff, 16'h0000);
    send_word(KIND_PAIR,        16'hffff, 16'hffff);
    send_word(KIND_PAIR,        16'hffff, 16'h0000);
    send_word(KIND_QUERY_PROBE, 16'hffff, 16'h0000);
    send_word(KIND_PAIR,        16'h5555, 16'haaaa);
    send_word(KIND_PAIR,        16'haaaa, 16'h5555);
    send_word(KIND_CLEAR,       16'h1234, 16'h4321);
    send_word(KIND_QUERY_PROBE, 16'h0000, 16'h0000);
    send_word(KIND_PAIR,        16'h0000, 16'hffff);
    send_word(KIND_QUERY_BUILD, 16'h0000, 16'hffff);
    finish_burst();

    // directed: first per build row, unmatched build rows padded
    apply_mode('{JK_RIGHT, ST_ANY, 1'b1, 1'b1});
    send_word(KIND_QUERY_BUILD, 16'h0000, 16'h1234);
    send_word(KIND_PAIR,        16'h0001, 16'h1234);
    send_word(KIND_PAIR,        16'h0002, 16'h1234);
    send_word(KIND_QUERY_BUILD, 16'h0000, 16'h1234);
    finish_burst();

    // directed: unsupported join kind; a clear still clears
    apply_mode('{JK_UNUSED_LO, ST_UNUSED_MID, 1'b0, 1'b1});
    send_word(KIND_PAIR,        16'h0003, 16'h0003);
    send_word(KIND_QUERY_PROBE, 16'h0003, 16'h0000);
    send_word(KIND_CLEAR,       16'h0000, 16'h0000);
    finish_burst();

    // directed: build rows claimed without build flags kept
    apply_mode('{JK_INNER, ST_ANY, 1'b0, 1'b0});
    send_word(KIND_PAIR,        16'h0004, 16'h0004);
    send_word(KIND_QUERY_BUILD, 16'h0000, 16'h0004);
    finish_burst();

    // random phases, idling pattern rotating, long hold-offs in some
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      apply_mode(PLAN[ph]);
      run_phase(PHASE_ITEMS, (ph % 4 == 0 && ph > 0) ? 30 : -1);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (16) @(posedge clk);
    $display("run: %0d words under %0d mode settings, %0d clears, %0d results checked",
             n_sent, n_settings, board.n_clears, board.n_checked);
    $display("run: %0d pairs kept, %0d mismatches", board.n_kept, board.n_errors);
    if (board.n_errors == 0 && board.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
